/* rtl/core/esae_pkg.sv */
// Shared types and constants for the encoder speed and angle estimator.
// No dependencies; imported by encoder_speed_angle_estimator_core.
package esae_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_COUNTER_MODULUS = 3'd0;
  localparam logic [2:0] CFG_COUNTS_PER_REV  = 3'd1;
  localparam logic [2:0] CFG_VELOCITY_GAIN   = 3'd2;
  localparam logic [2:0] CFG_RPM_GAIN        = 3'd3;
  localparam logic [2:0] CFG_ACCEL_GAIN      = 3'd4;

  // Reset values of the registers
  localparam logic [16:0] RST_COUNTER_MODULUS = 17'd65536;
  localparam logic [15:0] RST_COUNTS_PER_REV  = 16'd1000;
  localparam logic [31:0] RST_VELOCITY_GAIN   = 32'd205887;
  localparam logic [31:0] RST_RPM_GAIN        = 32'd3932160;
  localparam logic [31:0] RST_ACCEL_GAIN      = 32'd205887416;

  // Delta limits
  localparam logic signed [19:0] DELTA_MAX = 20'sd65536;
  localparam logic signed [19:0] DELTA_MIN = -20'sd65536;

  // Degrees per revolution, used as a multiplier operand
  localparam logic signed [32:0] DEG_PER_REV = 33'sd360;

  // Iteration counts of the shared compare/subtract unit
  localparam logic [4:0] MOD_STEPS = 5'd16;
  localparam logic [4:0] DIV_STEPS = 5'd25;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_SCALE,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL_VEL,
    ST_MUL_RPM,
    ST_MUL_ACC,
    ST_STORE,
    ST_FINISH
  } state_t;

endpackage

/* rtl/core/encoder_speed_angle_estimator_core.sv */
// Encoder speed and angle estimator, top level.
// Depends on esae_pkg (states, register indexes, constants).
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------
//  in      | in_valid / in_stall       | counter_value, count_down
//  out     | out_valid / out_stall     | delta_count, angle_q16, velocity_q16,
//          |                           | rpm_q16, accel_q16
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// in_stall stays high from the beat taken until the item leaves finish (16 mod
// steps, scale by 360, divider load, 25 quotient steps, three products plus one to
// collect, finish), so a new beat is not taken while an item is in flight.
// rst is synchronous; clears state and valid flags, loads config reset values.
// Finish holds, and in_stall with it, while the output register is still stalled;
// a result waiting under out_stall does not block the next input beat.
module encoder_speed_angle_estimator_core #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        counter_value,
  input  logic               count_down,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] delta_count,
  output logic [24:0]        angle_q16,
  output logic signed [48:0] velocity_q16,
  output logic signed [48:0] rpm_q16,
  output logic signed [49:0] accel_q16,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import esae_pkg::*;

  // Only the low COUNTER_WIDTH bits of the reading are meaningful.
  localparam logic [15:0] CUR_MASK = (COUNTER_WIDTH >= 16) ? 16'hFFFF :
                                     16'((64'd1 << COUNTER_WIDTH) - 64'd1);

  // Configuration registers
  logic [16:0] counter_modulus;
  logic [15:0] counts_per_rev;
  logic [31:0] velocity_gain;
  logic [31:0] rpm_gain;
  logic [31:0] accel_gain;

  // Sample state
  logic [15:0]        last_count;
  logic signed [17:0] last_delta;

  // Working registers
  state_t             state, state_next;
  logic [4:0]         step;
  logic signed [17:0] delta;
  logic signed [18:0] diff;
  logic [15:0]        rem;
  logic [24:0]        shreg;
  logic signed [52:0] prod;
  logic signed [48:0] vel_hold;
  logic signed [48:0] rpm_hold;
  logic signed [49:0] acc_hold;

  // Control from the sequencer
  logic               accept;
  logic               out_free;
  logic signed [19:0] mul_a;
  logic signed [32:0] mul_b;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // Wrap-corrected delta, formed in the cycle the beat is accepted
  // ---------------------------------------------------------------------
  logic [15:0]        cur;
  logic signed [19:0] c_ext, p_ext, m_ext, d_raw, d_dir, d_sat;
  logic signed [18:0] diff_new;

  always_comb begin
    cur   = counter_value & CUR_MASK;
    c_ext = $signed({4'b0, cur});
    p_ext = $signed({4'b0, last_count});
    m_ext = $signed({3'b0, counter_modulus});
    if (p_ext > c_ext) begin
      d_raw = c_ext + m_ext - p_ext;
    end else begin
      d_raw = c_ext - p_ext;
    end
    // counting down: d becomes -(M - d)
    d_dir = count_down ? (d_raw - m_ext) : d_raw;
    if (d_dir > DELTA_MAX) begin
      d_sat = DELTA_MAX;
    end else if (d_dir < DELTA_MIN) begin
      d_sat = DELTA_MIN;
    end else begin
      d_sat = d_dir;
    end
    diff_new = 19'(d_sat) - {last_delta[17], last_delta};
  end

  // ---------------------------------------------------------------------
  // Shared compare/subtract unit: one restoring-division step.
  // Shift the top bit of shreg into the partial remainder, subtract
  // counts_per_rev when it fits; the quotient bit enters shreg at the bottom.
  // ---------------------------------------------------------------------
  logic [16:0] trial;
  logic [17:0] sub;
  logic        fits;
  logic [15:0] rem_step;

  always_comb begin
    trial    = {rem, shreg[24]};
    sub      = {1'b0, trial} - {2'b0, counts_per_rev};
    fits     = !sub[17];
    rem_step = fits ? sub[15:0] : trial[15:0];
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = ST_MOD;
      ST_MOD:      if (step == MOD_STEPS - 5'd1) state_next = ST_SCALE;
      ST_SCALE:    state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      if (step == DIV_STEPS - 5'd1) state_next = ST_MUL_VEL;
      ST_MUL_VEL:  state_next = ST_MUL_RPM;
      ST_MUL_RPM:  state_next = ST_MUL_ACC;
      ST_MUL_ACC:  state_next = ST_STORE;
      ST_STORE:    state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs (stall and multiplier operand select)
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall = (state != ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      ST_SCALE: begin
        mul_a = $signed({4'b0, rem});
        mul_b = DEG_PER_REV;
      end
      ST_MUL_VEL: begin
        mul_a = {{2{delta[17]}}, delta};
        mul_b = $signed({1'b0, velocity_gain});
      end
      ST_MUL_RPM: begin
        mul_a = {{2{delta[17]}}, delta};
        mul_b = $signed({1'b0, rpm_gain});
      end
      ST_MUL_ACC: begin
        mul_a = {diff[18], diff};
        mul_b = $signed({1'b0, accel_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step            <= '0;
      out_valid       <= 1'b0;
      last_count      <= '0;
      last_delta      <= '0;
      counter_modulus <= RST_COUNTER_MODULUS;
      counts_per_rev  <= RST_COUNTS_PER_REV;
      velocity_gain   <= RST_VELOCITY_GAIN;
      rpm_gain        <= RST_RPM_GAIN;
      accel_gain      <= RST_ACCEL_GAIN;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COUNTER_MODULUS: counter_modulus <= cfg_data[16:0];
          CFG_COUNTS_PER_REV:  counts_per_rev  <= cfg_data[15:0];
          CFG_VELOCITY_GAIN:   velocity_gain   <= cfg_data;
          CFG_RPM_GAIN:        rpm_gain        <= cfg_data;
          CFG_ACCEL_GAIN:      accel_gain      <= cfg_data;
          default: ;  // drop writes beyond the register list
        endcase
      end

      // commit sample state as soon as the beat is taken
      if (accept) begin
        last_count <= cur;
        last_delta <= d_sat[17:0];
      end

      // advance the step counter inside the two division loops
      if ((state == ST_MOD && step != MOD_STEPS - 5'd1) ||
          (state == ST_DIV && step != DIV_STEPS - 5'd1)) begin
        step <= step + 5'd1;
      end else begin
        step <= '0;
      end

      // drain the output register, then refill it from the finished item
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          delta <= d_sat[17:0];
          diff  <= diff_new;
          rem   <= '0;
          shreg <= {cur, 9'b0};
        end
      end
      ST_MOD, ST_DIV: begin
        rem   <= rem_step;
        shreg <= {shreg[23:0], fits};
      end
      ST_DIV_LOAD: begin
        // numerator is rem*360 << 16; its top part seeds the remainder
        rem   <= prod[24:9];
        shreg <= {prod[8:0], 16'b0};
      end
      ST_MUL_RPM: vel_hold <= prod[48:0];
      ST_MUL_ACC: rpm_hold <= prod[48:0];
      ST_STORE:   acc_hold <= prod[49:0];
      default: ;
    endcase

    if (state == ST_FINISH && out_free) begin
      delta_count  <= delta;
      angle_q16    <= (counts_per_rev == 16'd0) ? 25'd0 : shreg;
      velocity_q16 <= vel_hold;
      rpm_q16      <= rpm_hold;
      accel_q16    <= acc_hold;
    end
  end

endmodule
